### rtl/tlq_pkg.sv
package tlq_pkg;

  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [2:0] VTX_START_L  = 3'd0;
  localparam logic [2:0] VTX_END_L    = 3'd1;
  localparam logic [2:0] VTX_END_R    = 3'd2;
  localparam logic [2:0] VTX_END_R2   = 3'd3;
  localparam logic [2:0] VTX_START_R  = 3'd4;
  localparam logic [2:0] VTX_LAST     = 3'd5;

  typedef enum logic [3:0] {
    F_IDLE,
    F_NORM,
    F_MULX,
    F_MULY,
    F_SQRT,
    F_MULA,
    F_MULB,
    F_DIV,
    F_PUSH
  } tlq_fstate_t;

  // One input segment as it arrives.
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic        [30:0] w;
    logic        [31:0] rgba;
  } tlq_line_t;

  // A classified segment with its finished offset, handed to the back end.
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic        [31:0] rgba;
  } tlq_seg_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/tlq_front.sv
module tlq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlq_pkg::tlq_line_t in_line,
  output logic               seg_valid,
  input  logic               seg_ready,
  output tlq_pkg::tlq_seg_t  seg
);

  tlq_pkg::tlq_fstate_t state, state_next;

  logic               hold_valid;
  tlq_pkg::tlq_line_t hold;
  tlq_pkg::tlq_line_t ln;
  logic               take;

  logic        zero, dxneg, dypos;
  logic [32:0] ax, ay, mag;
  logic        norm_done;
  logic [61:0] prod;
  logic [30:0] opa, opb;
  logic [63:0] rem, root, bitm;
  logic [63:0] rem_next, root_next, bitm_next;
  logic [31:0] len;
  logic [32:0] den;
  logic [32:0] qa_r, qb_r, qa_r_next, qb_r_next;
  logic [31:0] qa, qb, qa_next, qb_next;
  logic [3:0]  cnt;
  logic [32:0] dx, dy;

  assign in_ready = !hold_valid;
  assign take     = (state == tlq_pkg::F_IDLE) && hold_valid;

  assign dx = {hold.ex[31], hold.ex} - {hold.sx[31], hold.sx};
  assign dy = {hold.ey[31], hold.ey} - {hold.sy[31], hold.sy};

  assign mag       = (ax > ay) ? ax : ay;
  assign norm_done = (mag[32:31] == 2'b00) && mag[30];

  always_comb begin
    unique case (state)
      tlq_pkg::F_MULX: begin opa = ax[30:0]; opb = ax[30:0]; end
      tlq_pkg::F_MULY: begin opa = ay[30:0]; opb = ay[30:0]; end
      tlq_pkg::F_MULA: begin opa = ay[30:0]; opb = ln.w;     end
      default:         begin opa = ax[30:0]; opb = ln.w;     end
    endcase
  end
  assign prod = opa * opb;

  // Two square root steps per cycle.
  always_comb begin
    logic [63:0] r, q, b, t;
    r = rem; q = root; b = bitm;
    for (int i = 0; i < 2; i++) begin
      t = q + b;
      if (r >= t) begin
        r = r - t;
        q = (q >> 1) + b;
      end else begin
        q = q >> 1;
      end
      b = b >> 2;
    end
    rem_next = r; root_next = q; bitm_next = b;
  end

  assign den = {len, 1'b0};

  // Two restoring division steps per cycle on both quotients.
  always_comb begin
    logic [33:0] ta, tb;
    logic [32:0] ra, rb;
    logic [31:0] a, b;
    ra = qa_r; rb = qb_r; a = qa; b = qb;
    for (int i = 0; i < 2; i++) begin
      ta = {ra, a[31]};
      tb = {rb, b[31]};
      if (ta >= {1'b0, den}) begin
        ra = 33'(ta - {1'b0, den}); a = {a[30:0], 1'b1};
      end else begin
        ra = ta[32:0]; a = {a[30:0], 1'b0};
      end
      if (tb >= {1'b0, den}) begin
        rb = 33'(tb - {1'b0, den}); b = {b[30:0], 1'b1};
      end else begin
        rb = tb[32:0]; b = {b[30:0], 1'b0};
      end
    end
    qa_r_next = ra; qb_r_next = rb; qa_next = a; qb_next = b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlq_pkg::F_IDLE: if (take) state_next = tlq_pkg::F_NORM;
      tlq_pkg::F_NORM: begin
        if (zero) state_next = tlq_pkg::F_PUSH;
        else if (norm_done) state_next = tlq_pkg::F_MULX;
      end
      tlq_pkg::F_MULX: state_next = tlq_pkg::F_MULY;
      tlq_pkg::F_MULY: state_next = tlq_pkg::F_SQRT;
      tlq_pkg::F_SQRT: if (cnt == 4'd15) state_next = tlq_pkg::F_MULA;
      tlq_pkg::F_MULA: state_next = tlq_pkg::F_MULB;
      tlq_pkg::F_MULB: state_next = tlq_pkg::F_DIV;
      tlq_pkg::F_DIV:  if (cnt == 4'd15) state_next = tlq_pkg::F_PUSH;
      tlq_pkg::F_PUSH: if (seg_ready) state_next = tlq_pkg::F_IDLE;
      default:         state_next = tlq_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    seg_valid = (state == tlq_pkg::F_PUSH);
    seg.sx    = ln.sx;
    seg.sy    = ln.sy;
    seg.ex    = ln.ex;
    seg.ey    = ln.ey;
    seg.rgba  = ln.rgba;
    if (zero) begin
      seg.hx = '0;
      seg.hy = '0;
    end else begin
      seg.hx = dypos ? -$signed(qa) : $signed(qa);
      seg.hy = dxneg ? -$signed(qb) : $signed(qb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tlq_pkg::F_IDLE;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) hold_valid <= 1'b0;
      else if (in_valid && in_ready) hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold <= in_line;
    unique case (state)
      tlq_pkg::F_IDLE: if (take) begin
        ln    <= hold;
        ax    <= dx[32] ? -dx : dx;
        ay    <= dy[32] ? -dy : dy;
        zero  <= (dx == '0) && (dy == '0);
        dxneg <= dx[32];
        dypos <= !dy[32] && (dy != '0);
      end
      tlq_pkg::F_NORM: begin
        if (!zero && !norm_done) begin
          if (mag[32:31] != 2'b00) begin
            ax <= ax >> 1; ay <= ay >> 1;
          end else if (mag[32:22] == '0) begin
            ax <= ax << 8; ay <= ay << 8;
          end else begin
            ax <= ax << 1; ay <= ay << 1;
          end
        end
      end
      tlq_pkg::F_MULX: rem <= {2'b00, prod};
      tlq_pkg::F_MULY: begin
        rem  <= rem + {2'b00, prod};
        root <= '0;
        bitm <= 64'd1 << 62;
        cnt  <= '0;
      end
      tlq_pkg::F_SQRT: begin
        rem  <= rem_next;
        root <= root_next;
        bitm <= bitm_next;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) len <= root_next[31:0];
      end
      tlq_pkg::F_MULA: begin
        {qa_r, qa} <= {1'b0, {2'b00, prod} + {32'd0, len}};
      end
      tlq_pkg::F_MULB: begin
        {qb_r, qb} <= {1'b0, {2'b00, prod} + {32'd0, len}};
        cnt <= '0;
      end
      tlq_pkg::F_DIV: begin
        qa_r <= qa_r_next; qa <= qa_next;
        qb_r <= qb_r_next; qb <= qb_next;
        cnt  <= cnt + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/tlq_fifo.sv
module tlq_fifo #(
  parameter int DEPTH = tlq_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlq_pkg::tlq_seg_t in_seg,
  output logic              out_valid,
  input  logic              out_ready,
  output tlq_pkg::tlq_seg_t out_seg
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlq_pkg::tlq_seg_t mem [DEPTH];
  logic [IDX_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;
  logic              push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_seg   = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == IDX_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == IDX_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_seg;
  end

endmodule

### rtl/tlq_back.sv
module tlq_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              seg_valid,
  output logic              seg_ready,
  input  tlq_pkg::tlq_seg_t seg,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,
  output logic              m_tlast,
  output logic [2:0]        m_tuser
);

  logic [2:0]  vnum;
  logic        adv;
  logic        use_end, neg;
  logic [32:0] bx, by, ox, oy, sumx, sumy;

  assign adv       = seg_valid && (!m_tvalid || m_tready);
  assign seg_ready = adv && (vnum == tlq_pkg::VTX_LAST);

  always_comb begin
    case (vnum) inside
      tlq_pkg::VTX_END_L:                     begin use_end = 1'b1; neg = 1'b0; end
      tlq_pkg::VTX_END_R, tlq_pkg::VTX_END_R2: begin use_end = 1'b1; neg = 1'b1; end
      tlq_pkg::VTX_START_R:                   begin use_end = 1'b0; neg = 1'b1; end
      default:                                begin use_end = 1'b0; neg = 1'b0; end
    endcase
  end

  assign bx   = use_end ? {seg.ex[31], seg.ex} : {seg.sx[31], seg.sx};
  assign by   = use_end ? {seg.ey[31], seg.ey} : {seg.sy[31], seg.sy};
  assign ox   = {seg.hx[31], seg.hx};
  assign oy   = {seg.hy[31], seg.hy};
  assign sumx = neg ? bx - ox : bx + ox;
  assign sumy = neg ? by - oy : by + oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      vnum     <= tlq_pkg::VTX_START_L;
    end else if (adv) begin
      m_tvalid <= 1'b1;
      vnum     <= (vnum == tlq_pkg::VTX_LAST) ? tlq_pkg::VTX_START_L : vnum + 3'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {seg.rgba, tlq_pkg::sat33(sumy), tlq_pkg::sat33(sumx)};
      m_tuser <= vnum;
      m_tlast <= (vnum == tlq_pkg::VTX_LAST);
    end
  end

endmodule

### rtl/thick_line_quad_expander_core.sv
// Thick line to quad expander. Each input item is one line segment (start and end points
// and a full thickness in Q16.16, plus a packed RGBA color); it yields six vertex items
// forming two triangles in the order start-left, end-left, end-right, end-right,
// start-right, start-left, every one carrying the color, with the sixth marked by tlast.
// The offset is the perpendicular of end minus start, normalized through an exact
// integer square root and divided to half the thickness with round-half-up; a
// zero-length segment gets no offset. Vertex coordinates saturate to the signed 32-bit
// range. A front end takes segments into a holding register and works out the offset
// with one shared 31x31 multiplier, a square root unit and a pair of dividers that
// each retire two bits a cycle; a short queue hands finished segments to a back end
// that emits one vertex a cycle, while the receiver accepts, through an output register.
// In the front end a segment passes the normalizing shift, the square root and the
// divide, and that front end sets the sustained segment rate; zero-length segments
// skip the square root and the divide, so a run of them goes at the back end's pace.
// Vertex output keeps flowing while the next segment is being computed.
module thick_line_quad_expander_core #(
  parameter int FIFO_DEPTH = tlq_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96],
  // line_width[158:128], rgba[190:159], zero pad [191]
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vertex_x[31:0], vertex_y[63:32], vertex_rgba[95:64]
  output logic [95:0]  m_tdata,
  // vertex_number[2:0]
  output logic [2:0]   m_tuser,
  // last_vertex
  output logic         m_tlast
);

  tlq_pkg::tlq_line_t in_line;
  tlq_pkg::tlq_seg_t  f_seg, q_seg;
  logic               f_valid, f_ready, q_valid, q_ready;

  // Unpack the incoming item into the segment record.
  assign in_line.sx   = s_tdata[31:0];
  assign in_line.sy   = s_tdata[63:32];
  assign in_line.ex   = s_tdata[95:64];
  assign in_line.ey   = s_tdata[127:96];
  assign in_line.w    = s_tdata[158:128];
  assign in_line.rgba = s_tdata[190:159];

  // Offset computation; it holds one segment waiting while another is in work.
  tlq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_line   (in_line),
    .seg_valid (f_valid),
    .seg_ready (f_ready),
    .seg       (f_seg)
  );

  // Queue of finished segments between the two halves.
  tlq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_seg    (f_seg),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_seg   (q_seg)
  );

  // Vertex emission, one vertex per cycle into the output register while the receiver does not stall.
  tlq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (q_valid),
    .seg_ready (q_ready),
    .seg       (q_seg),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // The last flag rides only on the sixth vertex.
  a_last_is_sixth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == tlq_pkg::VTX_LAST)))
    else $error("tlast does not match the vertex number");

  // Within a segment the vertices follow each other without a gap and in order.
  a_vertex_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("vertex sequence broken inside a segment");

  // The end-right corner, which both triangles use, is emitted twice in a row with the same data.
  a_shared_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tuser == tlq_pkg::VTX_END_R) |=>
      m_tvalid && (m_tdata == $past(m_tdata)))
    else $error("repeated end-right vertex differs");

endmodule

### verif/tb_thick_line_quad_expander_core.sv
module tb_thick_line_quad_expander_core;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected or observed vertex, with every output field kept apart.
  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] rgba;
    logic [2:0]  num;
    logic        last;
  } vertex_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  thick_line_quad_expander_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Segments waiting to be driven, and the vertices they will produce.
  tlq_pkg::tlq_line_t segment_queue[$];
  vertex_t            vertex_queue[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_sender;
  bit  in_taken;
  int  fail_count;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer square root by the classic bit-pair method, exact for 64-bit inputs.
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Clamp a wide signed sum into the signed 32-bit range.
  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Work out the six vertices of one segment and queue them as expected results.
  task automatic expand_segment(input tlq_pkg::tlq_line_t seg);
    longint sx, sy, ex, ey, dx, dy, hx, hy;
    logic [63:0] ax, ay, m, len, den, mx, my, w;
    longint px[6];
    longint py[6];
    vertex_t v;
    sx = longint'(seg.sx);
    sy = longint'(seg.sy);
    ex = longint'(seg.ex);
    ey = longint'(seg.ey);
    w = {33'd0, seg.w};
    dx = ex - sx;
    dy = ey - sy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    hx = 0;
    hy = 0;
    // A zero-length segment keeps a zero offset; all vertices sit at the start.
    if (ax != 0 || ay != 0) begin
      m = (ax > ay) ? ax : ay;
      while (m >= (64'd1 << 31)) begin
        m = m >> 1;
        ax = ax >> 1;
        ay = ay >> 1;
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        ax = ax << 1;
        ay = ay << 1;
      end
      len = root_floor(ax * ax + ay * ay);
      den = 2 * len;
      mx = (ay * w + len) / den;
      my = (ax * w + len) / den;
      hx = (dy > 0) ? -longint'(mx) : longint'(mx);
      hy = (dx < 0) ? -longint'(my) : longint'(my);
    end
    px[0] = sx + hx; py[0] = sy + hy;
    px[1] = ex + hx; py[1] = ey + hy;
    px[2] = ex - hx; py[2] = ey - hy;
    px[3] = px[2];   py[3] = py[2];
    px[4] = sx - hx; py[4] = sy - hy;
    px[5] = px[0];   py[5] = py[0];
    for (int k = 0; k < 6; k++) begin
      v.vx = clamp32(px[k]);
      v.vy = clamp32(py[k]);
      v.rgba = seg.rgba;
      v.num = 3'(k);
      v.last = (3'(k) == tlq_pkg::VTX_LAST);
      vertex_queue.push_back(v);
    end
  endtask

  // Driver: at the falling edge present the next segment, or idle at random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // Hold the current item until it is taken.
    end else if (!hold_sender && segment_queue.size() != 0 &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
      s_tdata <= {1'b0, segment_queue[0].rgba, segment_queue[0].w, segment_queue[0].ey,
                  segment_queue[0].ex, segment_queue[0].sy, segment_queue[0].sx};
      s_tvalid <= 1'b1;
    end else begin
      s_tvalid <= 1'b0;
    end
    m_tready <= rst ? 1'b0 : ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Monitor: at the rising edge take accepted segments into the predictor and
  // compare accepted vertices with the oldest expectation.
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (!rst) begin
      in_taken <= s_tvalid && s_tready;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (s_tvalid && s_tready) begin
        expand_segment(segment_queue.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got.vx = m_tdata[31:0];
        got.vy = m_tdata[63:32];
        got.rgba = m_tdata[95:64];
        got.num = m_tuser;
        got.last = m_tlast;
        if (vertex_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected vertex x=%h y=%h rgba=%h num=%0d last=%0b",
                   $time, got.vx, got.vy, got.rgba, got.num, got.last);
        end else begin
          want = vertex_queue.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            $display("%0t: vertex mismatch expected x=%h y=%h rgba=%h num=%0d last=%0b",
                     $time, want.vx, want.vy, want.rgba, want.num, want.last);
            $display("%0t:                 actual   x=%h y=%h rgba=%h num=%0d last=%0b",
                     $time, got.vx, got.vy, got.rgba, got.num, got.last);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return 32'h7FFF_FFFF - $urandom_range(3, 0);
      1: return 32'h8000_0000 + $urandom_range(3, 0);
      2: return $urandom_range(2000, 0) - 1000;
      3: return ($urandom_range(400, 0) - 200) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic tlq_pkg::tlq_line_t rand_segment();
    tlq_pkg::tlq_line_t s;
    s.sx = rand_coord();
    s.sy = rand_coord();
    case ($urandom_range(7, 0))
      // Degenerate, axis-aligned and tiny segments exercise the special paths.
      0: begin s.ex = s.sx; s.ey = s.sy; end
      1: begin s.ex = s.sx; s.ey = rand_coord(); end
      2: begin s.ex = rand_coord(); s.ey = s.sy; end
      3: begin s.ex = s.sx + $urandom_range(2, 0) - 1; s.ey = s.sy + $urandom_range(1, 0); end
      default: begin s.ex = rand_coord(); s.ey = rand_coord(); end
    endcase
    case ($urandom_range(3, 0))
      0: s.w = $urandom_range(1, 0) ? 31'h7FFF_FFFF : 31'd0;
      1: s.w = 31'($urandom_range(20, 1) << 16);
      default: s.w = 31'($urandom);
    endcase
    s.rgba = $urandom;
    return s;
  endfunction

  function automatic tlq_pkg::tlq_line_t make_segment(input logic [31:0] sx, sy, ex, ey,
                                                      input logic [30:0] w,
                                                      input logic [31:0] c);
    tlq_pkg::tlq_line_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey; s.w = w; s.rgba = c;
    return s;
  endfunction

  task automatic wait_drained();
    while (segment_queue.size() != 0 || vertex_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    // Idle percentages for each random phase: none, sender, receiver, both.
    int idle_s[4] = '{0, 51, 0, 38};
    int idle_r[4] = '{0, 0, 51, 38};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_sender = 1'b0;
    in_taken = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero length, axis directions, diagonals, extremes and saturation.
    segment_queue.push_back(make_segment(0, 0, 0, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    segment_queue.push_back(make_segment(0, 0, 32'h0001_0000, 0, 31'h0002_0000, 32'h1122_3344));
    segment_queue.push_back(make_segment(0, 0, 0, 32'h0001_0000, 31'h0002_0000, 0));
    segment_queue.push_back(make_segment(0, 0, 32'hFFFF_0000, 0, 31'h0002_0000, 32'hA5A5_5A5A));
    segment_queue.push_back(make_segment(0, 0, 0, 32'hFFFF_0000, 31'h0002_0000, 32'h5A5A_A5A5));
    segment_queue.push_back(make_segment(0, 0, 32'h0003_0000, 32'h0004_0000, 31'h000A_0000, 1));
    segment_queue.push_back(make_segment(5, 7, 5, 8, 31'd1, 2));
    segment_queue.push_back(make_segment(0, 0, 1, 1, 31'd3, 3));
    segment_queue.push_back(make_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    segment_queue.push_back(make_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
    segment_queue.push_back(make_segment(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h0001_0000,
                                         31'h7FFF_FFFF, 32'h0F0F_0F0F));
    segment_queue.push_back(make_segment(32'h8000_0000, 0, 32'h8000_0000, 32'hFFFF_0000,
                                         31'h7FFF_FFFF, 32'hF0F0_F0F0));
    segment_queue.push_back(make_segment(32'h1234_5678, 32'h8765_4321, 32'h1234_5678,
                                         32'h8765_4321, 31'h4000_0000, 32'h8000_0001));
    segment_queue.push_back(make_segment(0, 0, 32'h7FFF_FFFF, 1, 31'd0, 32'h0000_00FF));
    wait_drained();

    // Random phases under each idling pattern; in the sender-idling phase a full stop
    // midway makes the sender pause until every vertex has come back.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_s[p];
      recv_stall_pct = idle_r[p];
      for (int i = 0; i < 75; i++) segment_queue.push_back(rand_segment());
      if (p == 1) begin
        while (segment_queue.size() >= 40) @(posedge clk);
        hold_sender = 1'b1;
        while (s_tvalid || vertex_queue.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
